// File: rtl/core/mpq_pkg.sv
// Shared types and constants for the max priority queue.
package mpq_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned OPC_W    = 2;
  localparam int unsigned STS_W    = 2;
  localparam int unsigned CNT_OUT_W = 7;

  typedef enum logic [OPC_W-1:0] {
    OP_INSERT  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_INSPECT = 2'd2
  } opcode_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Operation broadcast to every cell of the chain
  typedef struct packed {
    logic                    insert;
    logic                    remove;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

  // State a cell shows to its neighbors
  typedef struct packed {
    logic                    occ;
    logic                    ge;
    logic signed [VAL_W-1:0] value;
  } cell_link_t;

endpackage

// File: rtl/core/mpq_cell.sv
// One slot of the sorted chain: holds a value and its occupancy flag.
module mpq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mpq_pkg::cell_ctrl_t ctrl_i,
  input  mpq_pkg::cell_link_t left_i,
  input  mpq_pkg::cell_link_t right_i,
  output mpq_pkg::cell_link_t link_o
);
  import mpq_pkg::*;

  logic                    occ_q, occ_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic                    ge;

  // Flag whether this slot stays ahead of the value being inserted
  assign ge = occ_q && (val_q >= ctrl_i.value);

  assign link_o.occ   = occ_q;
  assign link_o.ge    = ge;
  assign link_o.value = val_q;

  // Shift left on remove, open a gap on insert, otherwise hold
  always_comb begin
    occ_d = occ_q;
    val_d = val_q;
    if (ctrl_i.remove) begin
      occ_d = right_i.occ;
      val_d = right_i.value;
    end else if (ctrl_i.insert && !ge) begin
      if (left_i.ge) begin
        occ_d = 1'b1;
        val_d = ctrl_i.value;
      end else begin
        occ_d = left_i.occ;
        val_d = left_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// File: rtl/core/max_priority_queue.sv
// Max priority queue built as a sorted chain of cells, largest value at the head.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | input     | in_valid_i/in_stall_o | opcode_i, value_i
//   out     | output    | out_valid_o/out_stall_i | removed_value_o, status_o, count_o,
//           |           |                     | top_valid_o, top_value_o
//
// One item per cycle while in_stall_o is low: the whole chain shifts at once, each cell looking
// only at its two neighbors and the broadcast value; the result is registered and
// appears in the cycle after the item is accepted.
// Reset empties the chain by clearing each cell's occupancy flag at once.
// While a result waits under out_stall_i, in_stall_o is raised and no item enters.
module max_priority_queue (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [mpq_pkg::OPC_W-1:0]       opcode_i,
  input  logic signed [mpq_pkg::VAL_W-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [mpq_pkg::VAL_W-1:0] removed_value_o,
  output logic [mpq_pkg::STS_W-1:0]       status_o,
  output logic [mpq_pkg::CNT_OUT_W-1:0]   count_o,
  output logic                            top_valid_o,
  output logic signed [mpq_pkg::VAL_W-1:0] top_value_o
);
  import mpq_pkg::*;

  localparam cell_link_t HEAD_LINK = '{occ: 1'b1, ge: 1'b1, value: '0};
  localparam cell_link_t TAIL_LINK = '{occ: 1'b0, ge: 1'b0, value: '0};

  logic                    accept;
  logic                    full, empty;
  logic [CNT_W-1:0]        count_q, count_d;
  cell_ctrl_t              ctrl;
  cell_link_t              link [CAPACITY];

  logic                    out_valid_q;
  logic signed [VAL_W-1:0] removed_q, removed_d;
  status_e                 status_q, status_d;
  logic [CNT_OUT_W-1:0]    count_out_q;
  logic                    top_valid_q, top_valid_d;
  logic signed [VAL_W-1:0] top_q, top_d;

  // Block new items while a result is held
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);

  // Decode the operation and work out the result
  always_comb begin
    ctrl.insert = 1'b0;
    ctrl.remove = 1'b0;
    ctrl.value  = value_i;
    count_d     = count_q;
    removed_d   = '0;
    status_d    = ST_OK;
    top_valid_d = !empty;
    top_d       = empty ? '0 : link[0].value;
    unique case (opcode_i)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.insert = accept;
          count_d     = count_q + CNT_W'(1);
          top_valid_d = 1'b1;
          top_d       = (!empty && link[0].ge) ? link[0].value : value_i;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          ctrl.remove = accept;
          count_d     = count_q - CNT_W'(1);
          removed_d   = link[0].value;
          top_valid_d = link[1].occ;
          top_d       = link[1].occ ? link[1].value : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // Build the chain, head fed by a permanent winner, tail by an empty slot
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_link_t left, right;
    if (i == 0) begin : g_head
      assign left = HEAD_LINK;
    end else begin : g_left
      assign left = link[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right = TAIL_LINK;
    end else begin : g_right
      assign right = link[i+1];
    end
    mpq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left),
      .right_i (right),
      .link_o  (link[i])
    );
  end

  // Track the fill level and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q   <= removed_d;
      status_q    <= status_d;
      count_out_q <= CNT_OUT_W'(count_d);
      top_valid_q <= top_valid_d;
      top_q       <= top_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign count_o         = count_out_q;
  assign top_valid_o     = top_valid_q;
  assign top_value_o     = top_q;

endmodule

// File: rtl/core/mpq_checker.sv
// Port-level checks for the max priority queue, bound to the top level.
module mpq_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic signed [mpq_pkg::VAL_W-1:0] removed_value_o,
  input logic [mpq_pkg::STS_W-1:0]        status_o,
  input logic [mpq_pkg::CNT_OUT_W-1:0]    count_o,
  input logic                             top_valid_o,
  input logic signed [mpq_pkg::VAL_W-1:0] top_value_o
);
  import mpq_pkg::*;

  // Top flag follows the count
  a_top_valid_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (top_valid_o == (count_o != '0)))
    else $error("top_valid disagrees with count");

  // Empty queue reports a zero top value
  a_top_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !top_valid_o) |-> (top_value_o == '0))
    else $error("top_value not zero on empty queue");

  // Remove on empty leaves nothing held and returns zero
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_EMPTY) |-> (count_o == '0 && removed_value_o == '0))
    else $error("empty status with items held");

  // Dropped insert only when full
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> (count_o == CNT_OUT_W'(CAPACITY)))
    else $error("full status below capacity");

  // Stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(top_value_o)
                                      && $stable(count_o) && $stable(removed_value_o)))
    else $error("stalled result changed");

endmodule

bind max_priority_queue mpq_checker u_mpq_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .removed_value_o (removed_value_o),
  .status_o        (status_o),
  .count_o         (count_o),
  .top_valid_o     (top_valid_o),
  .top_value_o     (top_value_o)
);

// File: tb/sv/tb_top.sv
// Self-checking testbench for the max priority queue.
module tb_top;
  import mpq_pkg::*;

  // Opcode outside the defined set; the block treats it as inspect
  localparam logic [OPC_W-1:0] OP_RESERVED = 2'd3;
  localparam int unsigned MIX_ITEMS_PER_PHASE = 420;

  typedef struct packed {
    logic signed [VAL_W-1:0] removed;
    status_e                 status;
    logic [CNT_OUT_W-1:0]    count;
    logic                    top_valid;
    logic signed [VAL_W-1:0] top;
  } reply_t;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic [OPC_W-1:0]        opcode_i    = '0;
  logic signed [VAL_W-1:0] value_i     = '0;
  logic                    out_stall_i = 1'b0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic signed [VAL_W-1:0] removed_value_o;
  logic [STS_W-1:0]        status_o;
  logic [CNT_OUT_W-1:0]    count_o;
  logic                    top_valid_o;
  logic signed [VAL_W-1:0] top_value_o;

  // Shadow copy of the queue contents and the replies still owed
  logic signed [VAL_W-1:0] shadow_entries [CAPACITY];
  int unsigned             shadow_count    = 0;
  reply_t                  queue_replies [$];
  int unsigned             bad_reply_count = 0;
  int unsigned             send_idle_pct   = 0;
  int unsigned             stall_pct       = 0;

  max_priority_queue uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .removed_value_o (removed_value_o),
    .status_o        (status_o),
    .count_o         (count_o),
    .top_valid_o     (top_valid_o),
    .top_value_o     (top_value_o)
  );

  always #2 clk_i = ~clk_i;

  // Lowest slot holding the largest value; caller ensures the queue is not empty
  function automatic int unsigned largest_slot();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < shadow_count; i++) begin
      if (shadow_entries[i] > shadow_entries[best]) best = i;
    end
    return best;
  endfunction

  // Apply one operation to the shadow queue and return the reply it yields
  function automatic reply_t apply_queue_op(input logic [OPC_W-1:0] op,
                                            input logic signed [VAL_W-1:0] val);
    reply_t      r;
    int unsigned slot;
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          shadow_entries[shadow_count] = val;
          shadow_count++;
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot = largest_slot();
          r.removed = shadow_entries[slot];
          shadow_entries[slot] = shadow_entries[shadow_count - 1];
          shadow_count--;
        end
      end
      default: ;
    endcase
    r.count = CNT_OUT_W'(shadow_count);
    if (shadow_count != 0) begin
      r.top_valid = 1'b1;
      r.top = shadow_entries[largest_slot()];
    end
    return r;
  endfunction

  // Send one item; entered and left just after a falling edge
  task automatic send_op(input logic [OPC_W-1:0] op, input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
    queue_replies.push_back(apply_queue_op(op, val));
    @(negedge clk_i);
  endtask

  // Small values so ties occur, plus extremes and full-range values
  function automatic logic signed [VAL_W-1:0] rand_value();
    case ($urandom_range(9))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2, 3, 4: return VAL_W'($signed($urandom_range(16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // Extremes, every opcode, empty removes and equal maxima
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_op(OP_REMOVE,   $urandom);
    send_op(OP_INSPECT,  $urandom);
    send_op(OP_RESERVED, $urandom);
    send_op(OP_INSERT,   32'sd0);
    send_op(OP_INSERT,   32'sh7FFF_FFFF);
    send_op(OP_INSERT,   32'sh8000_0000);
    send_op(OP_INSERT,   -32'sd1);
    send_op(OP_INSPECT,  $urandom);
    send_op(OP_RESERVED, $urandom);
    send_op(OP_REMOVE,   $urandom);
    repeat (3) send_op(OP_INSERT, 32'sd5);
    repeat (7) send_op(OP_REMOVE, $urandom);
  endtask

  // Fill to capacity, push past full, then drain past empty
  task automatic test_fill_and_drain();
    send_idle_pct = 13;
    stall_pct     = 13;
    while (shadow_count < CAPACITY) send_op(OP_INSERT, rand_value());
    repeat (3) send_op(OP_INSERT, rand_value());
    send_op(OP_INSPECT, $urandom);
    repeat (CAPACITY + 2) send_op(OP_REMOVE, $urandom);
  endtask

  // Random operations in bursts that alternately grow and shrink the queue
  task automatic test_random_mix(input int unsigned idle, input int unsigned stall);
    int unsigned      grow_pct;
    int unsigned      burst;
    int unsigned      pick;
    logic [OPC_W-1:0] op;
    send_idle_pct = idle;
    stall_pct     = stall;
    grow_pct      = 65;
    burst         = 0;
    for (int unsigned n = 0; n < MIX_ITEMS_PER_PHASE; n++) begin
      if (burst == 0) begin
        burst    = $urandom_range(10, 60);
        grow_pct = (grow_pct == 65) ? 30 : 65;
      end
      burst--;
      pick = $urandom_range(99);
      if (pick < grow_pct) op = OP_INSERT;
      else if (pick < 94) op = OP_REMOVE;
      else if (pick < 98) op = OP_INSPECT;
      else op = OP_RESERVED;
      send_op(op, (op == OP_INSERT) ? rand_value() : VAL_W'($urandom));
    end
  endtask

  // Drive the result stall at random
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < stall_pct);
  end

  function automatic void check_field(input string name, input logic [VAL_W-1:0] want,
                                      input logic [VAL_W-1:0] got);
    if (want !== got) begin
      bad_reply_count++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Compare each accepted result with the oldest pending reply
  always @(posedge clk_i) begin
    reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (queue_replies.size() == 0) begin
        bad_reply_count++;
        $display("%0t: result with none pending: removed %h status %0d count %0d",
                 $time, removed_value_o, status_o, count_o);
      end else begin
        want = queue_replies.pop_front();
        check_field("removed_value", want.removed, removed_value_o);
        check_field("status", VAL_W'(want.status), VAL_W'(status_o));
        check_field("count", VAL_W'(want.count), VAL_W'(count_o));
        check_field("top_valid", VAL_W'(want.top_valid), VAL_W'(top_valid_o));
        check_field("top_value", want.top, top_value_o);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_fill_and_drain();
    test_random_mix(0, 0);
    test_random_mix(52, 0);
    test_random_mix(0, 52);
    test_random_mix(13, 13);
    in_valid_i <= 1'b0;
    while (queue_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (bad_reply_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/mpq_pkg.sv
rtl/core/mpq_cell.sv
rtl/core/max_priority_queue.sv
rtl/core/mpq_checker.sv
tb/sv/tb_top.sv
